FILE: rtl/uub64_pkg.sv
// Package with item types, codes and character mapping functions for the line encoder.
`timescale 1ns / 1ps

package uub64_pkg;

    // Default number of bytes collected into one encoded line.
    localparam int LINE_BYTES_DEF = 45;
    // Largest number of characters one input item may cause.
    localparam int MAX_RESULTS = 64;

    // Operation codes of an input item.
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Values of the code_mode register.
    localparam logic MODE_UU  = 1'b0;
    localparam logic MODE_B64 = 1'b1;

    // Characters used by the encodings: the line feed by both, the others by one of them.
    localparam logic [6:0] CHAR_LF    = 7'd10;
    localparam logic [6:0] CHAR_BTICK = 7'h60;
    localparam logic [6:0] CHAR_PAD   = 7'h3d;
    localparam logic [6:0] CHAR_PLUS  = 7'h2b;
    localparam logic [6:0] CHAR_SLASH = 7'h2f;
    localparam logic [6:0] CHAR_SPACE = 7'h20;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last;
    } out_item_t;

    // A six-bit value in uuencode text: offset by a space, with zero as backquote.
    function automatic logic [6:0] uu_char(input logic [5:0] v);
        logic [6:0] ch;
        if (v == 6'd0)
        begin
            ch = CHAR_BTICK;
        end
        else
        begin
            ch = CHAR_SPACE + {1'b0, v};
        end
        return ch;
    endfunction

    // A six-bit value in the standard base64 alphabet.
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] ch;
        if (v < 6'd26)
        begin
            ch = 7'h41 + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            ch = 7'h61 + {1'b0, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            ch = 7'h30 + {1'b0, v - 6'd52};
        end
        else if (v == 6'd62)
        begin
            ch = CHAR_PLUS;
        end
        else
        begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

FILE: rtl/uub64_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module uub64_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 45
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/uuencode_base64_line_encoder.sv
// Top level of the uuencode / base64 line encoder: line store, sequencer and output register.
// A data byte that does not complete a line is stored and gives no character.
// A line is sent as a length character (uuencode), then for each three-byte group its bytes
// are read from the store and four characters are produced, then a line feed follows.
// No new item is taken while a line is being sent; bytes are read through the single store
// read port and characters come from the one character mapping unit. Reset (rst_n, async, low)
// empties the line and selects uuencode; the line store itself is not cleared.
`timescale 1ns / 1ps

module uuencode_base64_line_encoder
    import uub64_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_item,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_item
);

    // Widths that follow from the line length.
    localparam int CNT_W  = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W = $clog2(LINE_BYTES);
    localparam int BASE_W = CNT_W + 1;
    localparam int RES_W  = $clog2(MAX_RESULTS);
    localparam logic [CNT_W-1:0] LINE_LEN = CNT_W'(LINE_BYTES);
    localparam logic [RES_W-1:0] RES_LAST = RES_W'(MAX_RESULTS - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_LF   = 3'd4;
    localparam logic [2:0] ST_TR0  = 3'd5;
    localparam logic [2:0] ST_TR1  = 3'd6;

    logic [2:0]        state_reg,    state_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [CNT_W-1:0]  len_reg,      len_next;
    logic [BASE_W-1:0] base_reg,     base_next;
    logic [1:0]        sub_reg,      sub_next;
    logic [23:0]       grp_reg,      grp_next;
    logic              is_end_reg,   is_end_next;
    logic [RES_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              mode_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg,  out_item_next;

    logic              src_take;
    logic              out_free;
    logic              emit_go;
    logic [6:0]        emit_char;
    logic              emit_last;
    logic              emit_stop;
    logic [BASE_W-1:0] cap_idx;
    logic [BASE_W-1:0] rem;
    logic              pad;
    logic [5:0]        six;
    logic [7:0]        rd_data;
    logic [ADDR_W-1:0] rd_addr;

    // The block takes a new item only when the sequencer has finished the previous one.
    // A finished character may still sit in the output register at that point.
    assign src_stall = (state_reg != ST_IDLE);
    assign src_take  = src_valid && !src_stall;

    // The output register can load a new character when it is empty or being drained.
    assign out_free = !out_valid_reg || !dst_stall;

    // The line store: bytes are written as they arrive and read back one per cycle while a group is fetched.
    assign rd_addr = ADDR_W'(base_reg + BASE_W'(sub_reg));

    uub64_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (src_take && (src_item.operation == OP_DATA)),
        .wr_addr (ADDR_W'(count_reg)),
        .wr_data (src_item.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Index of the byte whose read data arrives in this cycle, and bytes left in the line.
    assign cap_idx = base_reg + BASE_W'(sub_reg) - BASE_W'(1);
    assign rem     = BASE_W'(len_reg) - base_reg;

    // In base64 the third character of a group is padding when only one byte remains,
    // and the fourth when one or two remain.
    assign pad = ((sub_reg == 2'd2) && (rem == BASE_W'(1))) ||
                 ((sub_reg == 2'd3) && (rem <= BASE_W'(2)));
    assign six = grp_reg[23:18];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        base_next     = base_reg;
        sub_next      = sub_reg;
        grp_next      = grp_reg;
        is_end_next   = is_end_reg;
        emit_cnt_next = emit_cnt_reg;
        emit_go       = 1'b0;
        emit_char     = CHAR_LF;
        emit_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (src_take)
                begin
                    base_next     = '0;
                    sub_next      = '0;
                    emit_cnt_next = '0;
                    if (src_item.operation == OP_DATA)
                    begin
                        if (count_reg + CNT_W'(1) == LINE_LEN)
                        begin
                            // The line is full: send it and start a new one.
                            count_next  = '0;
                            len_next    = LINE_LEN;
                            is_end_next = 1'b0;
                            state_next  = (mode_reg == MODE_UU) ? ST_LEN : ST_READ;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        // End of data: flush a partial line, then the uuencode empty line.
                        count_next  = '0;
                        len_next    = count_reg;
                        is_end_next = 1'b1;
                        if (count_reg != '0)
                        begin
                            state_next = (mode_reg == MODE_UU) ? ST_LEN : ST_READ;
                        end
                        else if (mode_reg == MODE_UU)
                        begin
                            state_next = ST_TR0;
                        end
                    end
                end
            end

            ST_LEN:
            begin
                if (out_free)
                begin
                    emit_go    = 1'b1;
                    emit_char  = uu_char(6'(len_reg));
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                // Addresses go out for sub 0 to 2; the store returns the data in the following cycle.
                if (sub_reg != 2'd0)
                begin
                    grp_next = {grp_reg[15:0],
                                (cap_idx < BASE_W'(len_reg)) ? rd_data : 8'd0};
                end
                if (sub_reg == 2'd3)
                begin
                    sub_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    sub_next = sub_reg + 2'd1;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit_go = 1'b1;
                    if (mode_reg == MODE_UU)
                    begin
                        emit_char = uu_char(six);
                    end
                    else
                    begin
                        emit_char = pad ? CHAR_PAD : b64_char(six);
                    end
                    grp_next = {grp_reg[17:0], 6'd0};
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd3)
                    begin
                        base_next  = base_reg + BASE_W'(3);
                        state_next = (base_reg + BASE_W'(3) >= BASE_W'(len_reg)) ?
                                     ST_LF : ST_READ;
                    end
                end
            end

            ST_LF:
            begin
                if (out_free)
                begin
                    emit_go   = 1'b1;
                    emit_char = CHAR_LF;
                    if (is_end_reg && (mode_reg == MODE_UU))
                    begin
                        state_next = ST_TR0;
                    end
                    else
                    begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_TR0:
            begin
                if (out_free)
                begin
                    emit_go    = 1'b1;
                    emit_char  = CHAR_BTICK;
                    state_next = ST_TR1;
                end
            end

            ST_TR1:
            begin
                if (out_free)
                begin
                    emit_go    = 1'b1;
                    emit_char  = CHAR_LF;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // An item never causes more than the result limit; the last kept character
        // closes the item.
        emit_stop = emit_go && (emit_cnt_reg == RES_LAST);
        if (emit_go)
        begin
            emit_cnt_next = emit_cnt_reg + RES_W'(1);
        end
        if (emit_stop)
        begin
            emit_last  = 1'b1;
            state_next = ST_IDLE;
        end
    end

    // Output register: loaded by the sequencer, emptied by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit_go)
        begin
            out_valid_next         = 1'b1;
            out_item_next.out_char = emit_char;
            out_item_next.last     = emit_last;
        end
        else if (out_valid_reg && !dst_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mode_reg      <= MODE_UU;
            out_valid_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            is_end_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            emit_cnt_reg  <= emit_cnt_next;
            is_end_reg    <= is_end_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        base_reg     <= base_next;
        sub_reg      <= sub_next;
        grp_reg      <= grp_next;
        out_item_reg <= out_item_next;
    end

    // The fill count never reaches a whole line while items are being taken.
    a_count_below_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (count_reg < LINE_LEN))
        else $error("line fill count reached a whole line while idle");

    // A line that is being sent holds at least one byte and no more than a line.
    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN || state_reg == ST_READ || state_reg == ST_EMIT) |->
        (len_reg != '0 && len_reg <= LINE_LEN))
        else $error("line length out of range during encoding");

    // Characters of a group are only produced for groups that start inside the line.
    a_group_inside_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (base_reg < BASE_W'(len_reg)))
        else $error("group start beyond the held bytes");

    // A character waiting in the output register is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dst_stall) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("stalled character was replaced");

endmodule

FILE: sim/uuencode_base64_line_encoder_tb.sv
// Self-checking testbench for the uuencode / base64 line encoder with a predictor and scoreboard.
`timescale 1ns / 1ps

module uuencode_base64_line_encoder_tb;
    import uub64_pkg::*;

    // Bytes per encoded line; the block is built with its default.
    localparam int LINE_BYTES = LINE_BYTES_DEF;
    // Cycles without any transfer on either channel before the run is abandoned.
    localparam int IDLE_LIMIT = 4000;
    // Cycles allowed after the last character for a byte that gives no character to settle.
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_style_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_stall;
    in_item_t   src_item = '0;
    logic       dst_valid;
    logic       dst_stall = 1'b0;
    out_item_t  dst_item;

    // Items waiting to be driven and characters the block is expected to produce.
    in_item_t   pending_items[$];
    out_item_t  expected_chars[$];

    // Predictor state: the bytes of the current line, how many there are, and the mode.
    logic [7:0] line_bytes_q[LINE_BYTES];
    int         line_fill = 0;
    logic       code_mode_q = MODE_UU;

    int         mismatch_count = 0;
    int         idle_cycles = 0;

    // Sender burst control.
    int         burst_left = 0;
    int         gap_left = 0;

    // Receiver stall control.
    stall_style_e stall_style = STALL_NONE;
    int           stall_window = 0;
    logic [2:0]   stall_phase = 3'd0;

    string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    uuencode_base64_line_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_item    (src_item),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .dst_item    (dst_item)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A six-bit value in uuencode text. Zero becomes a backquote so that
    // lines never carry trailing spaces.
    function automatic logic [6:0] uu_symbol(input logic [5:0] v);
        logic [6:0] ch;
        ch = (v == 6'd0) ? CHAR_BTICK : CHAR_SPACE + 7'(v);
        return ch;
    endfunction

    // A six-bit value looked up in the standard base64 alphabet.
    function automatic logic [6:0] b64_symbol(input logic [5:0] v);
        logic [7:0] c;
        c = b64_alphabet[int'(v)];
        return c[6:0];
    endfunction

    task automatic push_char(input logic [6:0] ch);
        out_item_t r;
        r.out_char = ch;
        r.last     = 1'b0;
        expected_chars.push_back(r);
    endtask

    // Encodes the first n bytes of the line. Bytes beyond n in the last group
    // read as zero; base64 replaces the characters that cover only padding by '='.
    task automatic encode_line(input int n);
        logic [7:0] b0, b1, b2;
        logic [5:0] s0, s1, s2, s3;
        int         rem;
        if (code_mode_q == MODE_UU)
        begin
            push_char(uu_symbol(6'(n)));
        end
        for (int i = 0; i < n; i += 3)
        begin
            b0  = line_bytes_q[i];
            b1  = (i + 1 < n) ? line_bytes_q[i + 1] : 8'h00;
            b2  = (i + 2 < n) ? line_bytes_q[i + 2] : 8'h00;
            s0  = b0[7:2];
            s1  = {b0[1:0], b1[7:4]};
            s2  = {b1[3:0], b2[7:6]};
            s3  = b2[5:0];
            rem = n - i;
            if (code_mode_q == MODE_UU)
            begin
                push_char(uu_symbol(s0));
                push_char(uu_symbol(s1));
                push_char(uu_symbol(s2));
                push_char(uu_symbol(s3));
            end
            else
            begin
                push_char(b64_symbol(s0));
                push_char(b64_symbol(s1));
                push_char((rem > 1) ? b64_symbol(s2) : CHAR_PAD);
                push_char((rem > 2) ? b64_symbol(s3) : CHAR_PAD);
            end
        end
        push_char(CHAR_LF);
    endtask

    // Works out the characters one accepted item causes and appends them to
    // the expected queue, with last set on the final one.
    task automatic encode_item(input in_item_t it);
        int        start;
        out_item_t tail;
        start = expected_chars.size();
        if (it.operation == OP_DATA)
        begin
            line_bytes_q[line_fill] = it.data_byte;
            line_fill++;
            if (line_fill == LINE_BYTES)
            begin
                encode_line(LINE_BYTES);
                line_fill = 0;
            end
        end
        else
        begin
            // End of data flushes a partial line; uuencode then adds its empty line.
            if (line_fill > 0)
            begin
                encode_line(line_fill);
            end
            line_fill = 0;
            if (code_mode_q == MODE_UU)
            begin
                push_char(CHAR_BTICK);
                push_char(CHAR_LF);
            end
        end
        if (expected_chars.size() > start)
        begin
            tail = expected_chars.pop_back();
            tail.last = 1'b1;
            expected_chars.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items in bursts separated by random gaps.
    // A payload held under stall is never changed, and each signal gets a
    // single nonblocking assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        logic     take;
        logic     next_valid;
        in_item_t next_item;
        take       = src_valid && !src_stall;
        next_valid = src_valid && !take;
        next_item  = src_item;
        // The predictor runs on every accepted input transfer.
        if (take)
        begin
            encode_item(src_item);
        end
        if (!next_valid)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                next_item  = pending_items.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                if (burst_left == 0)
                begin
                    // One burst in four runs straight into the next, which
                    // gives stretches with no idling at all.
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        src_valid <= next_valid;
        src_item  <= next_item;
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: windows of random length, each with its own
    // style, from no stall at all to stalling most cycles.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : stall_proc
        logic next_stall;
        if (stall_window == 0)
        begin
            stall_style  = stall_style_e'($urandom_range(0, 3));
            stall_window = $urandom_range(16, 96);
        end
        else
        begin
            stall_window--;
        end
        stall_phase = stall_phase + 3'd1;
        case (stall_style)
            STALL_NONE:    next_stall = 1'b0;
            STALL_SPARSE:  next_stall = ($urandom_range(0, 2) == 0);
            STALL_PATTERN: next_stall = (stall_phase < 3'd5);
            default:       next_stall = ($urandom_range(0, 7) != 0);
        endcase
        dst_stall <= next_stall;
    end

    // ------------------------------------------------------------------
    // Monitor: every output transfer is checked against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        out_item_t want;
        if (dst_valid && !dst_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          dst_item.out_char, dst_item.last));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (dst_item.out_char !== want.out_char)
                begin
                    report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                              dst_item.out_char, want.out_char));
                end
                if (dst_item.last !== want.last)
                begin
                    report_mismatch($sformatf("last %0b, expected %0b (char 0x%02h)",
                                              dst_item.last, want.last, want.out_char));
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing tasks
    // ------------------------------------------------------------------

    task automatic push_item(input logic op, input logic [7:0] b);
        in_item_t it;
        it.operation = op;
        it.data_byte = b;
        pending_items.push_back(it);
    endtask

    // Waits until every item has been taken and every character has come,
    // then lets a byte that gives no character settle inside the block.
    task automatic wait_idle();
        while (pending_items.size() != 0 || src_valid || expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the mode register; only called while the block is idle.
    task automatic write_mode(input logic m);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        code_mode_q = m;
    endtask

    // Short hand-picked lines: empty, one, two and three bytes, with all-zero
    // and all-one bytes, and values that reach both ends of each alphabet.
    task automatic queue_directed();
        @(negedge clk);
        push_item(OP_END, 8'hFF);
        push_item(OP_DATA, 8'h00);
        push_item(OP_END, 8'h00);
        push_item(OP_DATA, 8'hFF);
        push_item(OP_DATA, 8'h80);
        push_item(OP_END, 8'h5A);
        push_item(OP_DATA, 8'hFB);
        push_item(OP_DATA, 8'hFF);
        push_item(OP_DATA, 8'hBF);
        push_item(OP_END, 8'h00);
    endtask

    // Random traffic built from whole sequences (a run of data bytes
    // closed by end of data). Long runs may fill a line and spill into the
    // next; zero-length runs give back-to-back end markers.
    task automatic queue_random(input int target);
        int count;
        int run;
        count = 0;
        @(negedge clk);
        while (count < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: run = $urandom_range(0, 8);
                6, 7:             run = $urandom_range(40, 50);
                8:                run = $urandom_range(1, 3);
                default:          run = 0;
            endcase
            repeat (run) push_item(OP_DATA, 8'($urandom));
            push_item(OP_END, 8'($urandom));
            count += run + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines in both modes.
        write_mode(MODE_UU);
        queue_directed();
        wait_idle();
        write_mode(MODE_B64);
        queue_directed();
        wait_idle();

        // Random phases alternate the mode. Halfway through each the sender
        // pauses until every expected character has come. A batch ends with
        // its last whole sequence, so it runs somewhat past its target.
        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase[0] ? MODE_B64 : MODE_UU);
            queue_random(15);
            wait_idle();
            queue_random(14);
            wait_idle();
        end

        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/uub64_pkg.sv
rtl/uub64_ram.sv
rtl/uuencode_base64_line_encoder.sv
sim/uuencode_base64_line_encoder_tb.sv
